// File: design/sorted_gap_query_engine_assert.svh
// Assertion macros shared by the checker of the sorted gap query engine.
// No dependencies; included by bare file name.
`ifndef SORTED_GAP_QUERY_ENGINE_ASSERT_SVH
`define SORTED_GAP_QUERY_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SGQE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgqe assertion failed");

// Next-cycle implication, checked outside reset
`define SGQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgqe assertion failed");

`endif

// File: design/sgqe_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the sorted gap query engine. No dependencies.
package sgqe_pkg;

  // Table and field sizes
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned POS_W       = 30;
  localparam int unsigned LINE_W      = 30;
  localparam int unsigned ANS_W       = 30;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IN_W        = FUNC_W + POS_W;
  localparam int unsigned OUT_W       = STAT_W + ANS_W;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_TDATA_W   = ((POS_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W   = ((ANS_W + 7) / 8) * 8;

  localparam logic [LINE_W-1:0] LINE_RESET = {LINE_W{1'b1}};

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Read address source
  typedef enum logic [2:0] {
    ADDR_ZERO   = 3'd0,
    ADDR_LAST   = 3'd1,
    ADDR_MID    = 3'd2,
    ADDR_IDX_M1 = 3'd3,
    ADDR_IDX_M2 = 3'd4
  } addr_sel_e;

  // Result kind loaded into the output register
  typedef enum logic [2:0] {
    RES_OK    = 3'd0,
    RES_EMPTY = 3'd1,
    RES_FULL  = 3'd2,
    RES_LOW   = 3'd3,
    RES_HIGH  = 3'd4,
    RES_GAP   = 3'd5
  } res_e;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      clear;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      cap_first;
    logic      cap_last;
    logic      search_init;
    logic      mid_load;
    logic      search_step;
    logic      ins_init;
    logic      ins_shift;
    logic      ins_place;
    logic      res_load;
    res_e      res_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              cnt_zero;
    logic              cnt_full;
    logic              idx_zero;
    logic              idx_one;
    logic              p_le_first;
    logic              p_ge_last;
    logic              rd_gt_p;
    logic              search_done;
  } stat_t;

endpackage

// File: design/sorted_gap_query_engine.sv
// Top level of the sorted gap query engine: joins controller and datapath.
// Depends on sgqe_pkg, sgqe_ctrl and sgqe_datapath.
//
//  channel  | direction | handshake                 | word
//  s_axis   | in        | s_axis_tvalid/tready      | tuser func, tdata position
//  m_axis   | out       | m_axis_tvalid/tready      | tuser status, tdata answer
//  cfg      | in        | cfg_valid/ready           | line_length
//
// One item at a time. Clear, flagged items and unused codes go straight from
// dispatch to the result. Query: the line ends are checked first, else a
// lower-bound search follows (up to 11 probes for a full table). Insert:
// markers above the new one are shifted up one at a time through the single
// read/write port pair of the marker memory.
// Reset empties the table at once; no clearing pass. A stalled result holds
// in the output register while the next word is already accepted.
module sorted_gap_query_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sgqe_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // position[29:0], zero pad
  input  logic [sgqe_pkg::FUNC_W-1:0]    s_axis_tuser_i,  // func[1:0]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [sgqe_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // answer[29:0], zero pad
  output logic [sgqe_pkg::STAT_W-1:0]    m_axis_tuser_o,  // status[1:0]
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sgqe_pkg::LINE_W-1:0]    cfg_wdata_i      // line_length
);

  sgqe_pkg::cmd_t              cmd;
  sgqe_pkg::stat_t             stat;
  logic [sgqe_pkg::IN_W-1:0]   in_data;
  logic [sgqe_pkg::OUT_W-1:0]  out_data;

  assign cfg_ready_o = 1'b1;

  // Internal words keep the code in the low bits
  assign in_data        = {s_axis_tdata_i[sgqe_pkg::POS_W-1:0], s_axis_tuser_i};
  assign m_axis_tuser_o = out_data[sgqe_pkg::STAT_W-1:0];
  assign m_axis_tdata_o = sgqe_pkg::M_TDATA_W'(out_data[sgqe_pkg::OUT_W-1:sgqe_pkg::STAT_W]);

  sgqe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sgqe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data)
  );

endmodule

// File: design/sgqe_datapath.sv
// Datapath of the sorted gap query engine: marker memory, search and
// insert registers, config register and output word. Uses sgqe_pkg.
module sgqe_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sgqe_pkg::IN_W-1:0]   in_data_i,
  input  logic                        cfg_we_i,
  input  logic [sgqe_pkg::LINE_W-1:0] cfg_wdata_i,
  input  sgqe_pkg::cmd_t              cmd_i,
  output sgqe_pkg::stat_t             stat_o,
  output logic [sgqe_pkg::OUT_W-1:0]  out_data_o
);

  // Marker memory, one write and one registered read per cycle
  logic [sgqe_pkg::POS_W-1:0] mem_q [sgqe_pkg::MAX_ENTRIES];
  logic [sgqe_pkg::POS_W-1:0] rdata_q;

  logic [sgqe_pkg::LINE_W-1:0] line_q;
  logic [sgqe_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [sgqe_pkg::FUNC_W-1:0] func_q;
  logic [sgqe_pkg::POS_W-1:0]  pos_q;
  logic [sgqe_pkg::POS_W-1:0]  lo_val_q, hi_val_q;
  logic [sgqe_pkg::CNT_W-1:0]  lo_q, hi_q, mid_q, idx_q;
  logic [sgqe_pkg::STAT_W-1:0] stat_q;
  logic [sgqe_pkg::ANS_W-1:0]  ans_q;

  logic [sgqe_pkg::CNT_W-1:0]  span, mid_calc, mid_inc;
  logic [sgqe_pkg::CNT_W-1:0]  last_idx, idx_m1, idx_m2;
  logic [sgqe_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [sgqe_pkg::POS_W-1:0]  wr_data;
  logic                        wr_en;
  logic                        rd_lt_p;
  logic [sgqe_pkg::STAT_W-1:0] res_stat;
  logic [sgqe_pkg::ANS_W-1:0]  res_ans;

  // Address arithmetic
  assign span     = hi_q - lo_q;
  assign mid_calc = lo_q + (span >> 1);
  assign mid_inc  = mid_q + sgqe_pkg::CNT_W'(1);
  assign last_idx = cnt_q - sgqe_pkg::CNT_W'(1);
  assign idx_m1   = idx_q - sgqe_pkg::CNT_W'(1);
  assign idx_m2   = idx_q - sgqe_pkg::CNT_W'(2);

  always_comb begin
    case (cmd_i.rd_sel)
      sgqe_pkg::ADDR_ZERO:   rd_addr = '0;
      sgqe_pkg::ADDR_LAST:   rd_addr = last_idx[sgqe_pkg::ADDR_W-1:0];
      sgqe_pkg::ADDR_MID:    rd_addr = mid_calc[sgqe_pkg::ADDR_W-1:0];
      sgqe_pkg::ADDR_IDX_M1: rd_addr = idx_m1[sgqe_pkg::ADDR_W-1:0];
      sgqe_pkg::ADDR_IDX_M2: rd_addr = idx_m2[sgqe_pkg::ADDR_W-1:0];
      default:               rd_addr = '0;
    endcase
  end

  // Insert writes either a shifted marker or the new one at idx
  assign wr_en   = cmd_i.ins_shift | cmd_i.ins_place;
  assign wr_addr = idx_q[sgqe_pkg::ADDR_W-1:0];
  assign wr_data = cmd_i.ins_shift ? rdata_q : pos_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Config register and entry count
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.ins_place) begin
      cnt_d = cnt_q + sgqe_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= sgqe_pkg::LINE_RESET;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        line_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
    end
  end

  assign rd_lt_p = rdata_q < pos_q;

  // Item, search and insert registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_data_i[sgqe_pkg::FUNC_W-1:0];
      pos_q  <= in_data_i[sgqe_pkg::IN_W-1:sgqe_pkg::FUNC_W];
    end
    if (cmd_i.cap_first) begin
      lo_val_q <= rdata_q;
    end
    if (cmd_i.cap_last) begin
      hi_val_q <= rdata_q;
    end
    if (cmd_i.search_init) begin
      lo_q <= '0;
      hi_q <= cnt_q;
    end
    if (cmd_i.mid_load) begin
      mid_q <= mid_calc;
    end
    // lo/hi values track the markers at k-1 and k
    if (cmd_i.search_step) begin
      if (rd_lt_p) begin
        lo_q     <= mid_inc;
        lo_val_q <= rdata_q;
      end else begin
        hi_q     <= mid_q;
        hi_val_q <= rdata_q;
      end
    end
    if (cmd_i.ins_init) begin
      idx_q <= cnt_q;
    end else if (cmd_i.ins_shift) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.res_load) begin
      stat_q <= res_stat;
      ans_q  <= res_ans;
    end
  end

  // Result word
  always_comb begin
    res_stat = sgqe_pkg::STAT_OK;
    res_ans  = '0;
    case (cmd_i.res_sel)
      sgqe_pkg::RES_OK:    res_stat = sgqe_pkg::STAT_OK;
      sgqe_pkg::RES_EMPTY: res_stat = sgqe_pkg::STAT_EMPTY;
      sgqe_pkg::RES_FULL:  res_stat = sgqe_pkg::STAT_FULL;
      sgqe_pkg::RES_LOW: begin
        if (lo_val_q != '0) begin
          res_ans = sgqe_pkg::ANS_W'(lo_val_q - sgqe_pkg::POS_W'(1));
        end
      end
      sgqe_pkg::RES_HIGH: begin
        if (line_q >= hi_val_q) begin
          res_ans = sgqe_pkg::ANS_W'(line_q - hi_val_q);
        end
      end
      sgqe_pkg::RES_GAP: res_ans = sgqe_pkg::ANS_W'((hi_val_q - lo_val_q) >> 1);
      default:           res_stat = sgqe_pkg::STAT_OK;
    endcase
  end

  // Status to controller
  assign stat_o.func        = func_q;
  assign stat_o.cnt_zero    = (cnt_q == '0);
  assign stat_o.cnt_full    = (cnt_q >= sgqe_pkg::CNT_W'(sgqe_pkg::MAX_ENTRIES));
  assign stat_o.idx_zero    = (idx_q == '0);
  assign stat_o.idx_one     = (idx_q == sgqe_pkg::CNT_W'(1));
  assign stat_o.p_le_first  = (pos_q <= lo_val_q);
  assign stat_o.p_ge_last   = (pos_q >= rdata_q);
  assign stat_o.rd_gt_p     = (rdata_q > pos_q);
  assign stat_o.search_done = rd_lt_p ? (mid_inc == hi_q) : (lo_q == mid_q);

  assign out_data_o = {ans_q, stat_q};

endmodule

// File: design/sgqe_ctrl.sv
// Controller of the sorted gap query engine: sequences clear, insert and
// query work and owns the handshake state. Uses sgqe_pkg.
module sgqe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  sgqe_pkg::stat_t stat_i,
  output sgqe_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DISP = 9'b000000010,
    ST_IRD  = 9'b000000100,
    ST_ICMP = 9'b000001000,
    ST_QRD1 = 9'b000010000,
    ST_QCHK = 9'b000100000,
    ST_SRD  = 9'b001000000,
    ST_SCMP = 9'b010000000,
    ST_RESP = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  sgqe_pkg::res_e res_q, res_d;
  logic           out_valid_q, out_valid_d;
  logic           slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = sgqe_pkg::ADDR_ZERO;
    cmd_o.res_sel = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat_i.func)
          sgqe_pkg::FUNC_CLEAR: begin
            cmd_o.clear = 1'b1;
            res_d       = sgqe_pkg::RES_OK;
            state_d     = ST_RESP;
          end
          sgqe_pkg::FUNC_INSERT: begin
            if (stat_i.cnt_full) begin
              res_d   = sgqe_pkg::RES_FULL;
              state_d = ST_RESP;
            end else begin
              cmd_o.ins_init = 1'b1;
              state_d        = ST_IRD;
            end
          end
          sgqe_pkg::FUNC_QUERY: begin
            if (stat_i.cnt_zero) begin
              res_d   = sgqe_pkg::RES_EMPTY;
              state_d = ST_RESP;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = sgqe_pkg::ADDR_ZERO;
              state_d      = ST_QRD1;
            end
          end
          default: begin
            res_d   = sgqe_pkg::RES_OK;
            state_d = ST_RESP;
          end
        endcase
      end
      // Insert: walk down from the end, one shifted marker per cycle
      ST_IRD: begin
        if (stat_i.idx_zero) begin
          cmd_o.ins_place = 1'b1;
          res_d           = sgqe_pkg::RES_OK;
          state_d         = ST_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = sgqe_pkg::ADDR_IDX_M1;
          state_d      = ST_ICMP;
        end
      end
      ST_ICMP: begin
        if (stat_i.rd_gt_p) begin
          cmd_o.ins_shift = 1'b1;
          if (stat_i.idx_one) begin
            state_d = ST_IRD;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = sgqe_pkg::ADDR_IDX_M2;
          end
        end else begin
          cmd_o.ins_place = 1'b1;
          res_d           = sgqe_pkg::RES_OK;
          state_d         = ST_RESP;
        end
      end
      // Query: smallest marker arrives, fetch the largest
      ST_QRD1: begin
        cmd_o.cap_first = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = sgqe_pkg::ADDR_LAST;
        state_d         = ST_QCHK;
      end
      ST_QCHK: begin
        cmd_o.cap_last = 1'b1;
        if (stat_i.p_le_first) begin
          res_d   = sgqe_pkg::RES_LOW;
          state_d = ST_RESP;
        end else if (stat_i.p_ge_last) begin
          res_d   = sgqe_pkg::RES_HIGH;
          state_d = ST_RESP;
        end else begin
          cmd_o.search_init = 1'b1;
          state_d           = ST_SRD;
        end
      end
      // Lower-bound search: each probe reads in ST_SRD and steps in ST_SCMP
      ST_SRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = sgqe_pkg::ADDR_MID;
        cmd_o.mid_load = 1'b1;
        state_d        = ST_SCMP;
      end
      ST_SCMP: begin
        cmd_o.search_step = 1'b1;
        if (stat_i.search_done) begin
          res_d   = sgqe_pkg::RES_GAP;
          state_d = ST_RESP;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= sgqe_pkg::RES_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/sgqe_checker.sv
// Port-level checker for the sorted gap query engine, bound to the top.
// Depends on sgqe_pkg and sorted_gap_query_engine_assert.svh.
`include "sorted_gap_query_engine_assert.svh"

module sgqe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_i,
  input logic                           m_axis_tvalid_i,
  input logic                           m_axis_tready_i,
  input logic [sgqe_pkg::M_TDATA_W-1:0] m_axis_tdata_i,
  input logic [sgqe_pkg::STAT_W-1:0]    m_axis_tuser_i
);

  logic [sgqe_pkg::STAT_W-1:0] stat;
  logic [sgqe_pkg::ANS_W-1:0]  ans;
  logic                        pad_zero;

  assign stat     = m_axis_tuser_i;
  assign ans      = m_axis_tdata_i[sgqe_pkg::ANS_W-1:0];
  assign pad_zero = (m_axis_tdata_i[sgqe_pkg::M_TDATA_W-1:sgqe_pkg::ANS_W] == '0);

  // Stalled result word holds
  `SGQE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i,
    m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

  // Only defined status codes leave the block
  `SGQE_ASSERT_IMP(a_stat_code, clk_i, rst_ni, m_axis_tvalid_i,
    stat == sgqe_pkg::STAT_OK || stat == sgqe_pkg::STAT_EMPTY || stat == sgqe_pkg::STAT_FULL)

  // Flagged words carry no distance
  `SGQE_ASSERT_IMP(a_flag_zero, clk_i, rst_ni, m_axis_tvalid_i && stat != sgqe_pkg::STAT_OK,
    ans == '0)

  // Pad bits above the answer stay zero
  `SGQE_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_i, pad_zero)

  // One item in flight: input closes right after an accept
  `SGQE_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_i,
    !s_axis_tready_i)

endmodule

bind sorted_gap_query_engine sgqe_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// File: bench/tb_sorted_gap_query_engine.sv
// Testbench for sorted_gap_query_engine: directed table, then marker sessions and a full fill.
// Results are checked against fixed directed-table values or an in-bench sorted marker table and gap predictor.
// Depends on sgqe_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_sorted_gap_query_engine;

  localparam int unsigned      HALF_PERIOD  = 6;
  localparam int unsigned      RESET_CYCLES = 5;
  localparam int unsigned      TAIL_CYCLES  = 8;
  localparam int unsigned      SINK_HOLD    = 500;
  localparam int unsigned      LIMIT_NS     = 60_000_000;
  localparam logic [sgqe_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [sgqe_pkg::POS_W-1:0]  POS_MAX     = {sgqe_pkg::POS_W{1'b1}};

  // One result word, status in the low bits
  typedef struct packed {
    logic [sgqe_pkg::ANS_W-1:0]  answer;
    logic [sgqe_pkg::STAT_W-1:0] status;
  } gap_result_t;

  // One row of the directed table
  typedef struct packed {
    logic [sgqe_pkg::FUNC_W-1:0] op;
    logic [sgqe_pkg::POS_W-1:0]  pos;
    logic                        fixed_on;
    gap_result_t                 fixed;
  } dir_row_t;

  localparam int unsigned DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{sgqe_pkg::FUNC_QUERY,  30'd5,       1'b1, '{30'd0, sgqe_pkg::STAT_EMPTY}},
    '{FUNC_UNUSED,           POS_MAX,     1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_INSERT, 30'd100,     1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  30'd100,     1'b1, '{30'd99, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  30'd1,       1'b1, '{30'd99, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  POS_MAX,     1'b1,
      '{sgqe_pkg::LINE_RESET - 30'd100, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_INSERT, 30'd100,     1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_INSERT, 30'd300,     1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_INSERT, POS_MAX,     1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  30'd200,     1'b0, '0},
    '{sgqe_pkg::FUNC_QUERY,  30'd101,     1'b0, '0},
    '{sgqe_pkg::FUNC_QUERY,  30'd300,     1'b0, '0},
    '{sgqe_pkg::FUNC_QUERY,  POS_MAX - 1, 1'b0, '0},
    '{sgqe_pkg::FUNC_QUERY,  POS_MAX,     1'b0, '0},
    '{sgqe_pkg::FUNC_INSERT, 30'd150,     1'b0, '0},
    '{sgqe_pkg::FUNC_QUERY,  30'd120,     1'b0, '0},
    '{sgqe_pkg::FUNC_CLEAR,  POS_MAX,     1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  30'd7,       1'b1, '{30'd0, sgqe_pkg::STAT_EMPTY}},
    '{sgqe_pkg::FUNC_INSERT, 30'd0,       1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  30'd0,       1'b0, '0},
    '{sgqe_pkg::FUNC_QUERY,  30'd9,       1'b0, '0},
    '{sgqe_pkg::FUNC_INSERT, 30'd1,       1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_QUERY,  30'd0,       1'b0, '0},
    '{FUNC_UNUSED,           30'd0,       1'b1, '{30'd0, sgqe_pkg::STAT_OK}},
    '{sgqe_pkg::FUNC_CLEAR,  30'd0,       1'b1, '{30'd0, sgqe_pkg::STAT_OK}}
  };

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [sgqe_pkg::S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [sgqe_pkg::FUNC_W-1:0]    s_axis_tuser_i  = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [sgqe_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic [sgqe_pkg::STAT_W-1:0]    m_axis_tuser_o;
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [sgqe_pkg::LINE_W-1:0]    cfg_wdata_i     = '0;

  // Predictor state: sorted markers, fill count, line length
  logic [sgqe_pkg::POS_W-1:0]  marker_tab [sgqe_pkg::MAX_ENTRIES];
  int unsigned                 marker_cnt = 0;
  logic [sgqe_pkg::LINE_W-1:0] line_len   = sgqe_pkg::LINE_RESET;

  gap_result_t         pending_q [$];
  gap_result_t         got_res;
  gap_result_t         want_res;
  int unsigned         mismatch_cnt = 0;
  int unsigned         result_cnt   = 0;
  bit                  idle_on       = 1'b1;
  bit                  sink_hold_req = 1'b0;

  sorted_gap_query_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // position[29:0], zero pad
    .s_axis_tuser_i  (s_axis_tuser_i),   // func[1:0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // answer[29:0], zero pad
    .m_axis_tuser_o  (m_axis_tuser_o),   // status[1:0]
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i)       // line_length
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Expected result of one word; updates the marker table
  function automatic gap_result_t predict_gap(input logic [sgqe_pkg::FUNC_W-1:0] op,
                                              input logic [sgqe_pkg::POS_W-1:0] pos);
    gap_result_t                r;
    int unsigned                i, lo, hi, mid;
    logic [sgqe_pkg::POS_W-1:0] first_m, last_m;
    r = '0;
    r.status = sgqe_pkg::STAT_OK;
    case (op)
      sgqe_pkg::FUNC_CLEAR: marker_cnt = 0;
      sgqe_pkg::FUNC_INSERT: begin
        if (marker_cnt >= sgqe_pkg::MAX_ENTRIES) begin
          r.status = sgqe_pkg::STAT_FULL;
        end else begin
          // equal markers stay ahead of the new one
          i = marker_cnt;
          while (i > 0 && marker_tab[i-1] > pos) begin
            marker_tab[i] = marker_tab[i-1];
            i--;
          end
          marker_tab[i] = pos;
          marker_cnt++;
        end
      end
      sgqe_pkg::FUNC_QUERY: begin
        if (marker_cnt == 0) begin
          r.status = sgqe_pkg::STAT_EMPTY;
        end else begin
          first_m = marker_tab[0];
          last_m  = marker_tab[marker_cnt-1];
          if (pos <= first_m) begin
            r.answer = (first_m == '0) ? '0 : first_m - sgqe_pkg::POS_W'(1);
          end else if (pos >= last_m) begin
            r.answer = (line_len >= last_m) ? line_len - last_m : '0;
          end else begin
            // lower bound: first marker not below pos
            lo = 0;
            hi = marker_cnt;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (marker_tab[mid] < pos) lo = mid + 1;
              else hi = mid;
            end
            r.answer = (marker_tab[lo] - marker_tab[lo-1]) >> 1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, sometimes long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Position near a stored marker, at an extreme, or uniform up to span
  function automatic logic [sgqe_pkg::POS_W-1:0] pick_pos(input int unsigned span);
    int unsigned                r;
    logic [sgqe_pkg::POS_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return POS_MAX;
    if (r < 40 && marker_cnt != 0) begin
      base = marker_tab[$urandom_range(0, marker_cnt - 1)];
      r = $urandom_range(0, 2);
      if (r == 0 && base != '0) return base - 1;
      if (r == 1 && base != POS_MAX) return base + 1;
      return base;
    end
    return sgqe_pkg::POS_W'($urandom_range(1, span));
  endfunction

  // Offer one word, predict on accept, then idle at random
  task automatic send_word(input logic [sgqe_pkg::FUNC_W-1:0] op,
                           input logic [sgqe_pkg::POS_W-1:0] pos,
                           input bit fixed_on = 1'b0, input gap_result_t fixed = '0);
    gap_result_t      pred;
    int unsigned      gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sgqe_pkg::S_TDATA_W'(pos);
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_gap(op, pos);
    pending_q.push_back(fixed_on ? fixed : pred);
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Line length write, only while idle
  task automatic write_line(input logic [sgqe_pkg::LINE_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    line_len = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Sessions: clear, a run of inserts, then mixed queries, inserts, unused codes and clears
  task automatic run_sessions(input int unsigned n_items, input int unsigned span);
    int unsigned sent, k, r;
    sent = 0;
    while (sent < n_items) begin
      send_word(sgqe_pkg::FUNC_CLEAR, pick_pos(span));
      sent++;
      k = $urandom_range(1, 40);
      repeat (k) begin
        send_word(sgqe_pkg::FUNC_INSERT, pick_pos(span));
        sent++;
      end
      k = $urandom_range(5, 40);
      repeat (k) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_word(sgqe_pkg::FUNC_QUERY, pick_pos(span));
          sent++;
        end else if (r < 85) begin
          send_word(sgqe_pkg::FUNC_INSERT, pick_pos(span));
          sent++;
        end else if (r < 92) begin
          send_word(FUNC_UNUSED, pick_pos(span));
          sent++;
        end else begin
          send_word(sgqe_pkg::FUNC_CLEAR, pick_pos(span));
          sent++;
        end
      end
    end
  endtask

  // Fill the table, shift deep, overflow it, query it full, then clear it
  task automatic run_fill();
    int unsigned i;
    send_word(sgqe_pkg::FUNC_CLEAR, '0);
    for (i = 0; i < sgqe_pkg::MAX_ENTRIES - 24; i++) begin
      send_word(sgqe_pkg::FUNC_INSERT,
                sgqe_pkg::POS_W'(i * 1000 + $urandom_range(0, 999)));
    end
    repeat (24) send_word(sgqe_pkg::FUNC_INSERT,
                          sgqe_pkg::POS_W'($urandom_range(1, POS_MAX)));
    repeat (4) send_word(sgqe_pkg::FUNC_INSERT, pick_pos(1_000_000));
    repeat (30) send_word(sgqe_pkg::FUNC_QUERY, pick_pos(1_000_000));
    send_word(sgqe_pkg::FUNC_QUERY, POS_MAX);
    send_word(sgqe_pkg::FUNC_CLEAR, POS_MAX);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_res = {m_axis_tdata_o[sgqe_pkg::ANS_W-1:0], m_axis_tuser_o};
      if (pending_q.size() == 0) begin
        if (mismatch_cnt < 10) $display("result %0d arrived with nothing pending", result_cnt);
        mismatch_cnt++;
      end else begin
        want_res = pending_q.pop_front();
        if (got_res.status !== want_res.status || got_res.answer !== want_res.answer) begin
          if (mismatch_cnt < 10)
            $display("result %0d: status exp %0d got %0d, answer exp %0d got %0d",
                     result_cnt, want_res.status, got_res.status,
                     want_res.answer, got_res.answer);
          mismatch_cnt++;
        end
      end
      result_cnt++;
    end
  end

  // Result side ready: random stalls, plus one long hold on request
  initial begin : sink_ctl
    int unsigned run_len, gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      m_axis_tready_i <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
      end else begin
        gap = idle_len();
        if (gap != 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Run limit
  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence
  initial begin : stim
    int unsigned i;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset line length
    for (i = 0; i < DIR_N; i++) begin
      send_word(DIR_ROWS[i].op, DIR_ROWS[i].pos, DIR_ROWS[i].fixed_on, DIR_ROWS[i].fixed);
    end
    drain();

    // short line: many markers lie beyond it
    write_line(30'd1000);
    run_sessions(60, 2000);
    drain();

    // shortest line, dense duplicates
    write_line(30'd1);
    run_sessions(40, 50);
    drain();

    // longest line, no idling, one long result-side hold
    write_line(sgqe_pkg::LINE_RESET);
    idle_on = 1'b0;
    sink_hold_req = 1'b1;
    run_sessions(60, POS_MAX);
    drain();
    idle_on = 1'b1;

    write_line(sgqe_pkg::LINE_W'($urandom_range(1_000_000, POS_MAX)));
    run_fill();
    drain();

    write_line(sgqe_pkg::LINE_W'($urandom_range(1, POS_MAX)));
    run_sessions(60, $urandom_range(100, POS_MAX));
    drain();

    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sorted_gap_query_engine.f
+incdir+design
design/sgqe_pkg.sv
design/sgqe_datapath.sv
design/sgqe_ctrl.sv
design/sorted_gap_query_engine.sv
design/sgqe_checker.sv
bench/tb_sorted_gap_query_engine.sv
